>>> design/adsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int DEF_TIME_BITS  = 32;
  localparam int DEF_LEVEL_BITS = 16;

  // duration registers and the sustain register
  localparam int TICK_BITS    = 24;
  localparam int SUSTAIN_BITS = 16;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam int ATTACK_RST  = 4800;
  localparam int DECAY_RST   = 4800;
  localparam int RELEASE_RST = 9600;
  localparam int SUSTAIN_RST = 49152;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;
  localparam logic [1:0] REG_SUSTAIN = 2'd3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } q_status_t;

endpackage

>>> design/adsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_front
// Input stage: takes one beat, decodes its kind and pushes it to the queue.
// ----------------------------------------------------------------------------
module adsr_front import adsr_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           kind,
  input  logic [TIME_BITS-1:0] time_stamp,
  input  q_status_t            q_stat,
  output logic                 push,
  output op_t                  push_op,
  output logic [TIME_BITS-1:0] push_ts
);

  logic                 fr_valid;
  op_t                  fr_op;
  logic [TIME_BITS-1:0] fr_ts;
  op_t                  op_dec;
  logic                 accept;

  always_comb begin
    unique case (kind)
      OP_SAMPLE:   op_dec = OP_SAMPLE;
      OP_NOTE_ON:  op_dec = OP_NOTE_ON;
      OP_NOTE_OFF: op_dec = OP_NOTE_OFF;
      default:     op_dec = OP_RESET;
    endcase
  end

  assign item_stall = fr_valid && q_stat.full;
  assign accept     = item_valid && !item_stall;
  assign push       = fr_valid && !q_stat.full;
  assign push_op    = fr_op;
  assign push_ts    = fr_ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= accept || (fr_valid && q_stat.full);
    end
    if (accept) begin
      fr_op <= op_dec;
      fr_ts <= time_stamp;
    end
  end

endmodule

>>> design/adsr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_queue
// Short command queue that decouples the input stage from the executor.
// ----------------------------------------------------------------------------
module adsr_queue import adsr_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  op_t                  push_op,
  input  logic [TIME_BITS-1:0] push_ts,
  input  logic                 pop,
  output op_t                  pop_op,
  output logic [TIME_BITS-1:0] pop_ts,
  output q_status_t            q_stat
);

  op_t                  op_mem [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] ts_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign q_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign q_stat.count = count;

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign pop_op  = op_mem[rd_ptr];
  assign pop_ts  = ts_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      op_mem[wr_ptr] <= push_op;
      ts_mem[wr_ptr] <= push_ts;
    end
  end

endmodule

>>> design/adsr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in LEVEL_BITS bits.
// ----------------------------------------------------------------------------
module adsr_div import adsr_pkg::*; #(
  parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [LEVEL_BITS+TICK_BITS-1:0] num,
  input  logic [TICK_BITS-1:0]            den,
  output logic                            done,
  output logic [LEVEL_BITS-1:0]           quo
);

  localparam int PW = LEVEL_BITS + TICK_BITS;
  localparam int CW = $clog2(LEVEL_BITS + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [TICK_BITS-1:0]  rem;
  logic [LEVEL_BITS-1:0] sr;
  logic [TICK_BITS:0]    trial;
  logic [TICK_BITS:0]    diff;
  logic                  ge;

  assign trial = {rem, sr[LEVEL_BITS-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});
  assign quo   = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(LEVEL_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      // high part is below den, so it seeds the remainder
      rem <= num[PW-1 -: TICK_BITS];
      sr  <= num[LEVEL_BITS-1:0];
    end else if (busy) begin
      rem <= ge ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
      sr  <= {sr[LEVEL_BITS-2:0], ge};
    end
  end

endmodule

>>> design/adsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_back
// Executor: holds the envelope state, runs each queued command, drives the
// result register. Attack/decay/release samples use a multiply and divide.
// ----------------------------------------------------------------------------
module adsr_back import adsr_pkg::*; #(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  q_status_t               q_stat,
  input  op_t                     q_op,
  input  logic [TIME_BITS-1:0]    q_ts,
  output logic                    pop,
  input  logic [TICK_BITS-1:0]    attack_ticks,
  input  logic [TICK_BITS-1:0]    decay_ticks,
  input  logic [TICK_BITS-1:0]    release_ticks,
  input  logic [SUSTAIN_BITS-1:0] sustain_level,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [LEVEL_BITS-1:0]   level,
  output logic                    released
);

  localparam int PW = LEVEL_BITS + TICK_BITS;
  localparam int LW = ((TIME_BITS > TICK_BITS) ? TIME_BITS : TICK_BITS) + 1;
  localparam int SW = (LEVEL_BITS > SUSTAIN_BITS) ? LEVEL_BITS : SUSTAIN_BITS;
  localparam logic [LEVEL_BITS-1:0] FULL    = '1;
  localparam logic [LEVEL_BITS-1:0] LOW_CUT =
    LEVEL_BITS'(((64'd1 << LEVEL_BITS) - 64'd1) / 64'd10000);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEL, ST_MUL, ST_DIV, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE, PH_ZERO
  } phase_t;

  state_t state;
  phase_t phase;

  logic                  note_active;
  logic [TIME_BITS-1:0]  on_time;
  logic [TIME_BITS-1:0]  off_time;
  logic [LEVEL_BITS-1:0] held_level;
  logic [LEVEL_BITS-1:0] current_level;

  logic [TIME_BITS-1:0]  life;
  logic [LEVEL_BITS-1:0] mul_x;
  logic [TICK_BITS-1:0]  mul_y;
  logic [TICK_BITS-1:0]  div_den;
  logic [LEVEL_BITS-1:0] sus;
  logic [PW-1:0]         product;
  logic                  div_start;
  logic                  div_done;
  logic [LEVEL_BITS-1:0] div_quo;

  // select stage
  logic [TICK_BITS-1:0]  a_nz;
  logic [TICK_BITS-1:0]  d_nz;
  logic [TICK_BITS-1:0]  r_nz;
  logic [LW-1:0]         life_x;
  logic [LW-1:0]         past_a;
  logic [LW-1:0]         r_left;
  logic [SW-1:0]         sus_w;
  logic [LEVEL_BITS-1:0] sus_sat;

  // finish stage
  logic [LEVEL_BITS-1:0] lvl_raw;
  logic [LEVEL_BITS-1:0] lvl_cut;

  assign a_nz    = (attack_ticks == '0)  ? TICK_BITS'(1) : attack_ticks;
  assign d_nz    = (decay_ticks == '0)   ? TICK_BITS'(1) : decay_ticks;
  assign r_nz    = (release_ticks == '0) ? TICK_BITS'(1) : release_ticks;
  assign life_x  = LW'(life);
  assign past_a  = life_x - LW'(a_nz);
  assign r_left  = LW'(r_nz) - life_x;
  assign sus_w   = SW'(sustain_level);
  assign sus_sat = (sus_w > SW'(FULL)) ? FULL : sus_w[LEVEL_BITS-1:0];

  assign pop = (state == ST_IDLE) && !q_stat.empty && (!result_valid || !result_stall);

  always_comb begin
    unique case (phase)
      PH_ATTACK:  lvl_raw = div_quo;
      PH_DECAY:   lvl_raw = FULL - div_quo;
      PH_SUSTAIN: lvl_raw = sus;
      PH_RELEASE: lvl_raw = div_quo;
      default:    lvl_raw = '0;
    endcase
    lvl_cut = (lvl_raw <= LOW_CUT) ? '0 : lvl_raw;
  end

  adsr_div #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (product),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_ZERO;
      note_active   <= 1'b0;
      on_time       <= '0;
      off_time      <= '0;
      held_level    <= '0;
      current_level <= '0;
      result_valid  <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      div_start <= (state == ST_MUL);
      // drop the beat once taken, unless a command reloads it now
      if (result_valid && !result_stall && !(pop && q_op != OP_SAMPLE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (q_op)
              OP_SAMPLE: begin
                life  <= q_ts - (note_active ? on_time : off_time);
                state <= ST_SEL;
              end
              OP_NOTE_ON: begin
                held_level   <= '0;
                on_time      <= q_ts;
                note_active  <= 1'b1;
                result_valid <= 1'b1;
                level        <= current_level;
                released     <= 1'b0;
              end
              OP_NOTE_OFF: begin
                off_time     <= q_ts;
                note_active  <= 1'b0;
                result_valid <= 1'b1;
                level        <= current_level;
                released     <= 1'b1;
              end
              default: begin
                note_active   <= 1'b0;
                current_level <= '0;
                on_time       <= '0;
                off_time      <= '0;
                result_valid  <= 1'b1;
                level         <= '0;
                released      <= 1'b1;
              end
            endcase
          end
        end
        ST_SEL: begin
          sus <= sus_sat;
          if (note_active) begin
            if (life_x <= LW'(a_nz)) begin
              phase   <= PH_ATTACK;
              mul_x   <= FULL;
              mul_y   <= life_x[TICK_BITS-1:0];
              div_den <= a_nz;
              state   <= ST_MUL;
            end else if (past_a <= LW'(d_nz)) begin
              phase   <= PH_DECAY;
              mul_x   <= FULL - sus_sat;
              mul_y   <= past_a[TICK_BITS-1:0];
              div_den <= d_nz;
              state   <= ST_MUL;
            end else begin
              phase <= PH_SUSTAIN;
              state <= ST_FIN;
            end
          end else if (life_x >= LW'(r_nz)) begin
            phase <= PH_ZERO;
            state <= ST_FIN;
          end else begin
            phase   <= PH_RELEASE;
            mul_x   <= held_level;
            mul_y   <= r_left[TICK_BITS-1:0];
            div_den <= r_nz;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          product <= PW'(mul_x) * PW'(mul_y);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // the attack, decay and sustain value is held before the low cut
          if (note_active) begin
            held_level <= lvl_raw;
          end
          current_level <= lvl_cut;
          result_valid  <= 1'b1;
          level         <= lvl_cut;
          released      <= !note_active;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/adsr_envelope_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Time-stamped linear ADSR envelope with an APB register port.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   item     | item_valid, item_stall, kind, time_stamp  | in
//   result   | result_valid, result_stall, level, released | out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | in/out
//
// A sample request runs from queue to result through select, one multiply,
// LEVEL_BITS steps of the serial divider and the finish state; the executor
// pops the next command only once back in idle. Sustain and zero-level samples
// skip the multiply and divide, other kinds finish in idle; the input stage
// registers each beat. Reset is synchronous, needs no clearing pass. A stalled
// result holds in its register while the input stage and two-entry queue fill.
// ----------------------------------------------------------------------------
module adsr_envelope_generator import adsr_pkg::*; #(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [1:0]               kind,
  input  logic [TIME_BITS-1:0]     time_stamp,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [LEVEL_BITS-1:0]    level,
  output logic                     released,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam logic [LEVEL_BITS-1:0] LOW_CUT =
    LEVEL_BITS'(((64'd1 << LEVEL_BITS) - 64'd1) / 64'd10000);
  localparam logic [SUSTAIN_BITS-1:0] SUSTAIN_INIT =
    SUSTAIN_BITS'(64'(SUSTAIN_RST) & ((64'd1 << LEVEL_BITS) - 64'd1));

  logic [TICK_BITS-1:0]    attack_ticks;
  logic [TICK_BITS-1:0]    decay_ticks;
  logic [TICK_BITS-1:0]    release_ticks;
  logic [SUSTAIN_BITS-1:0] sustain_level;
  logic [1:0]              reg_idx;
  logic                    cfg_write;

  q_status_t            q_stat;
  logic                 q_push;
  op_t                  q_push_op;
  logic [TIME_BITS-1:0] q_push_ts;
  logic                 q_pop;
  op_t                  q_pop_op;
  logic [TIME_BITS-1:0] q_pop_ts;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= TICK_BITS'(ATTACK_RST);
      decay_ticks   <= TICK_BITS'(DECAY_RST);
      release_ticks <= TICK_BITS'(RELEASE_RST);
      sustain_level <= SUSTAIN_INIT;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ATTACK:  attack_ticks  <= pwdata[TICK_BITS-1:0];
        REG_DECAY:   decay_ticks   <= pwdata[TICK_BITS-1:0];
        REG_RELEASE: release_ticks <= pwdata[TICK_BITS-1:0];
        default:     sustain_level <= pwdata[SUSTAIN_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = CFG_DATA_BITS'(attack_ticks);
      REG_DECAY:   prdata = CFG_DATA_BITS'(decay_ticks);
      REG_RELEASE: prdata = CFG_DATA_BITS'(release_ticks);
      default:     prdata = CFG_DATA_BITS'(sustain_level);
    endcase
  end

  adsr_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind      (kind),
    .time_stamp(time_stamp),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_op   (q_push_op),
    .push_ts   (q_push_ts)
  );

  adsr_queue #(
    .TIME_BITS(TIME_BITS)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .push_op(q_push_op),
    .push_ts(q_push_ts),
    .pop    (q_pop),
    .pop_op (q_pop_op),
    .pop_ts (q_pop_ts),
    .q_stat (q_stat)
  );

  adsr_back #(
    .TIME_BITS (TIME_BITS),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_op         (q_pop_op),
    .q_ts         (q_pop_ts),
    .pop          (q_pop),
    .attack_ticks (attack_ticks),
    .decay_ticks  (decay_ticks),
    .release_ticks(release_ticks),
    .sustain_level(sustain_level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .level        (level),
    .released     (released)
  );

`ifndef SYNTHESIS
  a_level_cut: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (level == '0 || level > LOW_CUT))
    else $error("result level inside the low cut band");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !q_pop)
    else $error("command popped while result register is stalled");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (q_stat.count <= $past(q_stat.count) || $past(q_push)))
    else $error("queue count grew on a pop without a push");
`endif

endmodule

>>> tb/tb_adsr_envelope_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_generator
// Self-checking bench for the ADSR envelope generator. A queue-fed driver
// sends note, sample and reset beats with random gaps, and a monitor stalls
// the result channel at random. Each accepted beat is run through an
// envelope predictor kept in the bench, and each result beat is compared
// with the oldest prediction. The duration and sustain registers are
// rewritten over the APB port between phases: a directed pass through
// attack, decay, sustain, release, retrigger and reset, then random note
// sequences under a range of settings.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  localparam int                TB = DEF_TIME_BITS;
  localparam int                LB = DEF_LEVEL_BITS;
  localparam longint unsigned   FULL_LEVEL  = (64'd1 << LB) - 1;
  localparam longint unsigned   LEVEL_FLOOR = FULL_LEVEL / 10000;
  localparam int unsigned       IDLE_LIMIT  = 4000;

  typedef struct {
    op_t           op;
    logic [TB-1:0] stamp;
    bit            drain;
  } env_beat_t;

  typedef struct {
    logic [LB-1:0] level;
    logic          released;
  } env_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [1:0]               kind = OP_SAMPLE;
  logic [TB-1:0]            time_stamp = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [LB-1:0]            level;
  logic                     released;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  adsr_envelope_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .time_stamp   (time_stamp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .level        (level),
    .released     (released),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register shadow
  logic [TICK_BITS-1:0]    attack_cfg  = TICK_BITS'(ATTACK_RST);
  logic [TICK_BITS-1:0]    decay_cfg   = TICK_BITS'(DECAY_RST);
  logic [TICK_BITS-1:0]    release_cfg = TICK_BITS'(RELEASE_RST);
  logic [SUSTAIN_BITS-1:0] sustain_cfg = SUSTAIN_BITS'(SUSTAIN_RST);

  // envelope state
  logic          gate_on    = 1'b0;
  logic [TB-1:0] on_stamp   = '0;
  logic [TB-1:0] off_stamp  = '0;
  logic [LB-1:0] peak_level = '0;
  logic [LB-1:0] out_level  = '0;

  env_beat_t     beats_to_send[$];
  env_result_t   levels_due[$];
  env_beat_t     next_beat;
  env_result_t   want;
  logic [TB-1:0] stamp_now = '0;
  int unsigned   queued = 0;
  int unsigned   mismatches = 0;
  int unsigned   results_seen = 0;
  int unsigned   send_gap = 0;
  int unsigned   stall_left = 0;
  int unsigned   idle_cycles = 0;
  bit            calm = 1'b0;

  function automatic longint unsigned dur(logic [TICK_BITS-1:0] ticks);
    return (ticks == 0) ? 64'd1 : 64'(ticks);
  endfunction

  function automatic env_result_t envelope_step(op_t op, logic [TB-1:0] now);
    logic [TB-1:0]   dt;
    longint unsigned life;
    longint unsigned a;
    longint unsigned d;
    longint unsigned r;
    longint unsigned s;
    longint unsigned lvl;
    env_result_t     res;
    a = dur(attack_cfg);
    d = dur(decay_cfg);
    r = dur(release_cfg);
    s = 64'(sustain_cfg);
    lvl = 0;
    case (op)
      OP_SAMPLE: begin
        if (gate_on) begin
          dt = now - on_stamp;
          life = 64'(dt);
          if (life <= a) begin
            lvl = FULL_LEVEL * life / a;
          end else if (life - a <= d) begin
            lvl = FULL_LEVEL - (life - a) * (FULL_LEVEL - s) / d;
          end else begin
            lvl = s;
          end
          peak_level = LB'(lvl);
        end else begin
          dt = now - off_stamp;
          life = 64'(dt);
          lvl = (life >= r) ? 64'd0 : 64'(peak_level) * (r - life) / r;
        end
        if (lvl <= LEVEL_FLOOR) lvl = 0;
        out_level = LB'(lvl);
      end
      OP_NOTE_ON: begin
        peak_level = '0;
        on_stamp = now;
        gate_on = 1'b1;
      end
      OP_NOTE_OFF: begin
        off_stamp = now;
        gate_on = 1'b0;
      end
      default: begin
        // held level survives a reset
        gate_on = 1'b0;
        out_level = '0;
        on_stamp = '0;
        off_stamp = '0;
      end
    endcase
    res.level = out_level;
    res.released = !gate_on;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flag_mismatch(string what, longint unsigned exp_val, longint unsigned act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t result %0d %s: expected %0d, got %0d", $time, results_seen, what,
               exp_val, act_val);
  endtask

  // driver: predict on each accepted beat, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        levels_due.push_back(envelope_step(op_t'(kind), time_stamp));
        send_gap = pick_gap();
      end
      if (!item_valid || !item_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (beats_to_send.size() != 0 &&
                     !(beats_to_send[0].drain && levels_due.size() != 0)) begin
          next_beat = beats_to_send.pop_front();
          item_valid <= 1'b1;
          kind <= next_beat.op;
          time_stamp <= next_beat.stamp;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (levels_due.size() == 0) begin
          flag_mismatch("arrived with nothing pending, level", 64'd0, 64'(level));
        end else begin
          want = levels_due.pop_front();
          if (level !== want.level)
            flag_mismatch("level", 64'(want.level), 64'(level));
          if (released !== want.released)
            flag_mismatch("released", 64'(want.released), 64'(released));
        end
      end
      if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("adsr_envelope_generator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ATTACK:  attack_cfg = value[TICK_BITS-1:0];
      REG_DECAY:   decay_cfg = value[TICK_BITS-1:0];
      REG_RELEASE: release_cfg = value[TICK_BITS-1:0];
      default:     sustain_cfg = value[SUSTAIN_BITS-1:0];
    endcase
  endtask

  task automatic set_envelope(logic [31:0] a, logic [31:0] d, logic [31:0] r, logic [31:0] s);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_RELEASE, r);
    write_reg(REG_SUSTAIN, s);
  endtask

  task automatic settle();
    while (beats_to_send.size() != 0 || item_valid || levels_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_beat(op_t op);
    env_beat_t b;
    b.op = op;
    b.stamp = stamp_now;
    // hold the sender until the pipe drains
    b.drain = (queued == 300) || ($urandom_range(0, 59) == 0);
    beats_to_send.push_back(b);
    queued++;
  endtask

  task automatic push_at(op_t op, logic [TB-1:0] t);
    stamp_now = t;
    push_beat(op);
  endtask

  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFF_FFFF;
      2:       return $urandom;
      3, 4, 5: return $urandom_range(1, 64);
      default: return $urandom_range(65, 5000);
    endcase
  endfunction

  function automatic logic [31:0] pick_sustain();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF;
      2:       return $urandom_range(0, 12);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TB-1:0] stride(longint unsigned span);
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $urandom_range(0, 32'(span / 3 + 2));
  endfunction

  task automatic queue_note();
    longint unsigned hold_span;
    longint unsigned rel_span;
    int unsigned     n;
    hold_span = dur(attack_cfg) + dur(decay_cfg);
    rel_span = dur(release_cfg);
    stamp_now += stride(hold_span / 4);
    push_beat(OP_NOTE_ON);
    n = $urandom_range(1, 7);
    repeat (n) begin
      stamp_now += stride(hold_span);
      push_beat(OP_SAMPLE);
      if ($urandom_range(0, 11) == 0) push_beat(OP_NOTE_ON);
    end
    stamp_now += stride(hold_span);
    push_beat(OP_NOTE_OFF);
    if ($urandom_range(0, 7) == 0) begin
      stamp_now += stride(rel_span);
      push_beat(OP_NOTE_OFF);
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      stamp_now += stride(rel_span);
      push_beat(OP_SAMPLE);
    end
  endtask

  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      stamp_now += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
      push_beat(op_t'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int unsigned base;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // short envelope, sustain below the low-level cut, time wrapping mid-attack
    set_envelope(10, 20, 40, 5);
    push_at(OP_SAMPLE, 32'd3);
    push_at(OP_NOTE_ON, 32'hFFFF_FFF8);
    push_at(OP_SAMPLE, 32'hFFFF_FFF8);
    push_at(OP_SAMPLE, 32'hFFFF_FFFD);
    push_at(OP_SAMPLE, 32'd2);
    push_at(OP_SAMPLE, 32'd12);
    push_at(OP_SAMPLE, 32'd22);
    push_at(OP_SAMPLE, 32'd500);
    push_at(OP_NOTE_ON, 32'd500);
    push_at(OP_SAMPLE, 32'd503);
    push_at(OP_NOTE_OFF, 32'd504);
    push_at(OP_NOTE_OFF, 32'd506);
    push_at(OP_SAMPLE, 32'd506);
    push_at(OP_SAMPLE, 32'd526);
    push_at(OP_SAMPLE, 32'd545);
    push_at(OP_SAMPLE, 32'd546);
    push_at(OP_NOTE_ON, 32'd600);
    push_at(OP_SAMPLE, 32'hFFFF_FFFF);
    push_at(OP_RESET, 32'hFFFF_FFFF);
    push_at(OP_SAMPLE, 32'hFFFF_FFFF);
    settle();

    // zero durations act as one tick, full-scale sustain
    set_envelope(0, 0, 0, 32'hFFFF);
    push_at(OP_NOTE_ON, 32'd0);
    push_at(OP_SAMPLE, 32'd0);
    push_at(OP_SAMPLE, 32'd1);
    push_at(OP_SAMPLE, 32'd2);
    push_at(OP_SAMPLE, 32'd3);
    push_at(OP_NOTE_OFF, 32'd3);
    push_at(OP_SAMPLE, 32'd3);
    push_at(OP_SAMPLE, 32'd4);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase % 3 == 1);
      if (phase == 0)
        set_envelope(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd0);
      else
        set_envelope(pick_ticks(), pick_ticks(), pick_ticks(), pick_sustain());
      base = queued;
      while (queued - base < 115) begin
        if ($urandom_range(0, 4) == 0)
          queue_noise();
        else
          queue_note();
      end
      settle();
    end

    repeat (64) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("adsr_envelope_generator verification clean");
    end else begin
      $display("adsr_envelope_generator verification failed");
    end
    $finish;
  end

endmodule
